// File: hdl/int8mp_pkg.sv
// Shared types and constants for the int8 max-pool window block.
// No dependencies; imported by the geometry, controller and top modules.
package int8mp_pkg;

  // Most negative int8 value, also the answer for an empty window
  localparam logic signed [7:0] SAMPLE_FLOOR = 8'sh80;

  // Width of a window coordinate, set by the 7-bit map size registers
  localparam int unsigned COORD_W = 7;

  // Command codes of an input item
  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_STRIDE_X  = 3'd0,
    REG_STRIDE_Y  = 3'd1,
    REG_KERNEL_X  = 3'd2,
    REG_KERNEL_Y  = 3'd3,
    REG_PAD_X     = 3'd4,
    REG_PAD_Y     = 3'd5,
    REG_IN_WIDTH  = 3'd6,
    REG_IN_HEIGHT = 3'd7
  } reg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_FLUSH,
    ST_HOLD
  } state_t;

  // Pooling configuration
  typedef struct packed {
    logic [3:0] stride_x;
    logic [3:0] stride_y;
    logic [3:0] kernel_x;
    logic [3:0] kernel_y;
    logic [2:0] pad_x;
    logic [2:0] pad_y;
    logic [6:0] in_width;
    logic [6:0] in_height;
  } cfg_t;

  // Clipped window of one query, bounds are [lo, hi)
  typedef struct packed {
    logic               empty;
    logic [COORD_W-1:0] x_lo;
    logic [COORD_W-1:0] x_hi;
    logic [COORD_W-1:0] y_lo;
    logic [COORD_W-1:0] y_hi;
    logic [3:0]         chan;
  } win_t;

endpackage

// File: hdl/int8mp_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module int8mp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/int8mp_geom.sv
// Window geometry: places and clips the pooling window of a query.
// Depends on int8mp_pkg (cfg_t, win_t, COORD_W).
module int8mp_geom #(
  parameter int unsigned MAX_WIDTH    = 64,
  parameter int unsigned MAX_HEIGHT   = 64,
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned MAX_KERNEL   = 8
) (
  input  logic               clk,
  input  logic               load,
  input  int8mp_pkg::cfg_t   cfg,
  input  logic [5:0]         row,
  input  logic [5:0]         col,
  input  logic [3:0]         chan,
  output int8mp_pkg::win_t   win
);
  import int8mp_pkg::*;

  // Caps that fit the register widths
  localparam logic [6:0] W_CAP = 7'((MAX_WIDTH > 127) ? 127 : MAX_WIDTH);
  localparam logic [6:0] H_CAP = 7'((MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT);
  localparam logic [3:0] K_CAP = 4'((MAX_KERNEL > 15) ? 15 : MAX_KERNEL);

  win_t       win_r;
  win_t       win_nxt;
  logic [6:0] size_x;
  logic [6:0] size_y;
  logic [14:0] ax_x;
  logic [14:0] ax_y;
  logic        chan_bad;

  // Clip one axis; returns {empty, lo, hi}
  function automatic logic [14:0] clip_axis(input logic [5:0] pos,
                                            input logic [3:0] stride,
                                            input logic [2:0] pad,
                                            input logic [3:0] kern,
                                            input logic [6:0] size);
    logic [9:0]         prod;
    logic signed [12:0] org;
    logic signed [12:0] fin;
    logic signed [12:0] lo;
    logic signed [12:0] hi;
    logic signed [12:0] lim;
    logic [3:0]         kc;
    logic [6:0]         k;
    logic               none;
    prod = 10'(pos) * 10'(stride);
    org  = $signed({3'b000, prod}) - $signed({10'd0, pad});
    kc   = (kern > K_CAP) ? K_CAP : kern;
    k    = ({3'b000, kc} > size) ? size : {3'b000, kc};
    fin  = org + $signed({6'd0, k});
    lim  = $signed({6'd0, size});
    lo   = (org < 13'sd0) ? 13'sd0 : org;
    hi   = (fin < lim) ? fin : lim;
    none = (lo >= hi);
    return {none, lo[6:0], hi[6:0]};
  endfunction

  // Saturate the map size, clip both axes and flag an out-of-range channel
  always_comb begin
    size_x   = (cfg.in_width > W_CAP) ? W_CAP : cfg.in_width;
    size_y   = (cfg.in_height > H_CAP) ? H_CAP : cfg.in_height;
    ax_x     = clip_axis(col, cfg.stride_x, cfg.pad_x, cfg.kernel_x, size_x);
    ax_y     = clip_axis(row, cfg.stride_y, cfg.pad_y, cfg.kernel_y, size_y);
    chan_bad = (32'(chan) >= MAX_CHANNELS);

    win_nxt.empty = chan_bad | ax_x[14] | ax_y[14];
    win_nxt.x_lo  = ax_x[13:7];
    win_nxt.x_hi  = ax_x[6:0];
    win_nxt.y_lo  = ax_y[13:7];
    win_nxt.y_hi  = ax_y[6:0];
    win_nxt.chan  = chan;
  end

  // Hold the window of the accepted query
  always_ff @(posedge clk) begin
    if (load) begin
      win_r <= win_nxt;
    end
  end

  assign win = win_r;

endmodule

// File: hdl/int8mp_ctrl.sv
// Query controller: walks the clipped window through the feature memory,
// keeps the running maximum and holds the result register.
// Depends on int8mp_pkg (state_t, win_t, cmd_t, SAMPLE_FLOOR).
module int8mp_ctrl #(
  parameter int unsigned MAX_WIDTH    = 64,
  parameter int unsigned MAX_HEIGHT   = 64,
  parameter int unsigned MAX_CHANNELS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_cmd,
  output logic                    in_ready,
  output logic                    query_load,
  input  int8mp_pkg::win_t        win,
  output logic                    rd_en,
  output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)
              + ((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)
              + ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] rd_addr,
  input  logic [7:0]              rd_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [7:0]       out_max_value,
  output logic                    out_window_empty
);
  import int8mp_pkg::*;

  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  state_t              state_r;
  state_t              state_nxt;
  logic [COORD_W-1:0]  x_r;
  logic [COORD_W-1:0]  x_nxt;
  logic [COORD_W-1:0]  y_r;
  logic [COORD_W-1:0]  y_nxt;
  logic signed [7:0]   best_r;
  logic signed [7:0]   best_nxt;
  logic                pend_r;
  logic                pend_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic signed [7:0]   out_max_r;
  logic                out_empty_r;
  logic                x_last;
  logic                y_last;
  logic                out_load;

  assign x_last = (COORD_W'(x_r + 1'b1) == win.x_hi);
  assign y_last = (COORD_W'(y_r + 1'b1) == win.y_hi);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (cmd_t'(in_cmd) == CMD_QUERY)) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        state_nxt = win.empty ? ST_HOLD : ST_SCAN;
      end
      ST_SCAN: begin
        if (x_last && y_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_ready   = 1'b0;
    query_load = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        query_load = in_valid && (cmd_t'(in_cmd) == CMD_QUERY);
      end
      ST_SCAN: begin
        rd_en = 1'b1;
      end
      ST_HOLD: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Read address of the current window position
  assign rd_addr = {YW'(y_r), XW'(x_r), CW'(win.chan)};

  // Advance the window walk and fold returned samples into the maximum
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    best_nxt = best_r;
    pend_nxt = rd_en;
    if (state_r == ST_INIT) begin
      x_nxt    = win.x_lo;
      y_nxt    = win.y_lo;
      best_nxt = SAMPLE_FLOOR;
    end else if (state_r == ST_SCAN) begin
      if (x_last) begin
        x_nxt = win.x_lo;
        y_nxt = COORD_W'(y_r + 1'b1);
      end else begin
        x_nxt = COORD_W'(x_r + 1'b1);
      end
    end
    if (pend_r && ($signed(rd_data) > best_r)) begin
      best_nxt = $signed(rd_data);
    end
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    best_r <= best_nxt;
    if (out_load) begin
      out_max_r   <= best_r;
      out_empty_r <= win.empty;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_max_value    = out_max_r;
  assign out_window_empty = out_empty_r;

endmodule

// File: hdl/int8_max_pool_window_top.sv
// int8 max-pool window engine: feature map store plus pooled-maximum queries.
// Store: a store can be transferred every cycle while no query is in progress, no result.
// Query: the clipped window is walked with one memory read per cycle (no reads when empty);
// the next transfer is accepted once the result has been loaded and the block is idle again.
// Reset (rst_n, synchronous): registers to defaults, control cleared; the
// feature memory is not cleared and reads as undefined until written.
module int8_max_pool_window_top #(
  parameter int unsigned MAX_WIDTH    = 64,
  parameter int unsigned MAX_HEIGHT   = 64,
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned MAX_KERNEL   = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [5:0]        in_row,
  input  logic [5:0]        in_col,
  input  logic [3:0]        in_chan,
  input  logic signed [7:0] in_sample,
  // Result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] out_max_value,
  output logic              out_window_empty,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import int8mp_pkg::*;

  localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned AW    = YW + XW + CW;
  localparam int unsigned DEPTH = 1 << AW;

  cfg_t          cfg_r;
  cfg_t          cfg_nxt;
  logic          cfg_wr;
  reg_idx_t      cfg_idx;
  win_t          win;
  logic          query_load;
  logic          st_ok;
  logic          st_en;
  logic [AW-1:0] st_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_STRIDE_X:  cfg_nxt.stride_x  = pwdata[3:0];
        REG_STRIDE_Y:  cfg_nxt.stride_y  = pwdata[3:0];
        REG_KERNEL_X:  cfg_nxt.kernel_x  = pwdata[3:0];
        REG_KERNEL_Y:  cfg_nxt.kernel_y  = pwdata[3:0];
        REG_PAD_X:     cfg_nxt.pad_x     = pwdata[2:0];
        REG_PAD_Y:     cfg_nxt.pad_y     = pwdata[2:0];
        REG_IN_WIDTH:  cfg_nxt.in_width  = pwdata[6:0];
        REG_IN_HEIGHT: cfg_nxt.in_height = pwdata[6:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stride_x  <= 4'd1;
      cfg_r.stride_y  <= 4'd1;
      cfg_r.kernel_x  <= 4'd2;
      cfg_r.kernel_y  <= 4'd2;
      cfg_r.pad_x     <= 3'd0;
      cfg_r.pad_y     <= 3'd0;
      cfg_r.in_width  <= 7'd64;
      cfg_r.in_height <= 7'd64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back a register
  always_comb begin
    case (cfg_idx)
      REG_STRIDE_X:  prdata = 32'(cfg_r.stride_x);
      REG_STRIDE_Y:  prdata = 32'(cfg_r.stride_y);
      REG_KERNEL_X:  prdata = 32'(cfg_r.kernel_x);
      REG_KERNEL_Y:  prdata = 32'(cfg_r.kernel_y);
      REG_PAD_X:     prdata = 32'(cfg_r.pad_x);
      REG_PAD_Y:     prdata = 32'(cfg_r.pad_y);
      REG_IN_WIDTH:  prdata = 32'(cfg_r.in_width);
      REG_IN_HEIGHT: prdata = 32'(cfg_r.in_height);
      default:       prdata = '0;
    endcase
  end

  // Write a stored sample; drop stores outside the map bounds
  assign st_ok   = (32'(in_row) < MAX_HEIGHT) && (32'(in_col) < MAX_WIDTH)
                && (32'(in_chan) < MAX_CHANNELS);
  assign st_en   = in_valid && in_ready && (cmd_t'(in_cmd) == CMD_STORE) && st_ok;
  assign st_addr = {YW'(in_row), XW'(in_col), CW'(in_chan)};

  int8mp_geom #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_geom (
    .clk  (clk),
    .load (query_load),
    .cfg  (cfg_r),
    .row  (in_row),
    .col  (in_col),
    .chan (in_chan),
    .win  (win)
  );

  int8mp_ctrl #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_cmd           (in_cmd),
    .in_ready         (in_ready),
    .query_load       (query_load),
    .win              (win),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_max_value    (out_max_value),
    .out_window_empty (out_window_empty)
  );

  int8mp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_feature_ram (
    .clk     (clk),
    .wr_en   (st_en),
    .wr_addr (st_addr),
    .wr_data (in_sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
